FILE: hw/rtl/ndd_pkg.sv
package ndd_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int          MAX_POINTS = 16;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [WORD_W-1:0] POS_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] NEG_MAX  = {1'b1, {(WORD_W-1){1'b0}}};

  function automatic logic [WORD_W-1:0] mag_of(input logic [WORD_W-1:0] v);
    mag_of = v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [WORD_W:0] sat_sub(input logic [WORD_W-1:0] a,
                                              input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] r;
    r = a - b;
    if ((a[WORD_W-1] != b[WORD_W-1]) && (r[WORD_W-1] != a[WORD_W-1])) begin
      sat_sub = {1'b1, a[WORD_W-1] ? NEG_MAX : POS_MAX};
    end else begin
      sat_sub = {1'b0, r};
    end
  endfunction

  function automatic logic [WORD_W:0] sat_add(input logic [WORD_W-1:0] a,
                                              input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] r;
    r = a + b;
    if ((a[WORD_W-1] == b[WORD_W-1]) && (r[WORD_W-1] != a[WORD_W-1])) begin
      sat_add = {1'b1, a[WORD_W-1] ? NEG_MAX : POS_MAX};
    end else begin
      sat_add = {1'b0, r};
    end
  endfunction

  function automatic logic [WORD_W:0] from_mag(input logic neg,
                                               input logic [2*WORD_W-1:0] m);
    logic [WORD_W-1:0] lim;
    lim = neg ? NEG_MAX : POS_MAX;
    if ((m[2*WORD_W-1:WORD_W] != '0) || (m[WORD_W-1:0] > lim)) begin
      from_mag = {1'b1, lim};
    end else begin
      from_mag = {1'b0, neg ? (~m[WORD_W-1:0] + 1'b1) : m[WORD_W-1:0]};
    end
  endfunction

endpackage

FILE: hw/rtl/ndd_if.sv
interface ndd_in_if
  import ndd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [3:0]        point_index;
  logic [WORD_W-1:0] point_x;
  logic [WORD_W-1:0] point_y;
  logic [WORD_W-1:0] query_x;
  modport source (output valid, kind, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink (input valid, kind, point_index, point_x, point_y, query_x,
                output ready);
endinterface

interface ndd_out_if
  import ndd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   value;
  logic [STATUS_W-1:0] status;
  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

interface ndd_cfg_if
  import ndd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/newton_divided_difference_interp.sv
// newton divided-difference interpolator
// in_: load requests (kind 0) store a point (x, y) at point_index, no result;
//   evaluate requests (kind 1) return one result on out_ with value and status
// cfg_: writes point_count (2..16 used, clamped), marks the table stale; taken
//   only while idle and no request is accepted in the same cycle
// all values are signed Q31.32 in 64 bits; overflow saturates (status 2),
//   duplicate x gives value 0, status 1 until the next rebuild
// points, coefficients and the scratch column live in one-port-read memories
// a load is written to the point memories when accepted; an evaluation of n points
//   forms two products per point (one for the last), each from 4 partial products
//   on a 32x32 multiplier, plus reads and accumulate
// a rebuild first copies the n y values and runs up to n*(n-1)/2 divisions on
//   the bit-serial divider (one quotient bit per cycle)
// one request is worked at a time; in_ready is low while busy or while a result
//   waits in the output register for out_ready
// reset: synchronous rst_n clears control, point_count goes to 2, the table is
//   stale; point memories are undefined until loaded
module newton_divided_difference_interp
  import ndd_pkg::*;
#(
  parameter int FRAC_BITS  = 32
) (
  input  logic clk,
  input  logic rst_n,
  ndd_in_if.sink    in_if,
  ndd_out_if.source out_if,
  ndd_cfg_if.sink   cfg_if
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int W2 = 2 * WORD_W;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CPY   = 14'b00000000000010,
    S_BRD   = 14'b00000000000100,
    S_BRD2  = 14'b00000000001000,
    S_DIV   = 14'b00000000010000,
    S_DWR   = 14'b00000000100000,
    S_ERD   = 14'b00000001000000,
    S_EMUL  = 14'b00000010000000,
    S_EACC  = 14'b00000100000000,
    S_ETRM  = 14'b00001000000000,
    S_EMUL2 = 14'b00010000000000,
    S_OUT   = 14'b00100000000000,
    S_CPY2  = 14'b01000000000000,
    S_ERD2  = 14'b10000000000000
  } state_t;

  logic [WORD_W-1:0] x_mem [MAX_POINTS];
  logic [WORD_W-1:0] y_mem [MAX_POINTS];
  logic [WORD_W-1:0] c_mem [MAX_POINTS];
  logic [WORD_W-1:0] w_mem [MAX_POINTS];

  state_t state_r;
  logic [COUNT_W-1:0] count_r;
  logic stale_r;
  logic [STATUS_W-1:0] berr_r;
  logic [IW:0] n_r, it_r, i_r;
  logic [WORD_W-1:0] a_r, b_r, xa_r, q_r, term_r, acc_r, cf_r;
  logic sat_r;
  logic ovalid_r;
  logic [WORD_W-1:0] oval_r;
  logic [STATUS_W-1:0] ostat_r;

  // memory ports
  logic [IW-1:0] xr_a, wr_a;
  logic [WORD_W-1:0] xr_d, wr_d, yr_d, cr_d;
  logic [IW-1:0] rd_a;

  // multiplier: 4 partial products
  logic [WORD_W-1:0] ma_r, mb_r;
  logic [W2-1:0] mp_r;
  logic [2:0] mstep_r;
  logic mneg_r;

  // divider
  logic [W2-1:0] dn_r;
  logic [WORD_W-1:0] dd_r, drem_r;
  logic [W2-1:0] dq_r;
  logic [7:0] dcnt_r;
  logic dneg_r;

  logic in_acc;
  assign in_if.ready  = (state_r == S_IDLE) && !ovalid_r;
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = (state_r == S_IDLE) && !in_acc;
  assign out_if.valid  = ovalid_r;
  assign out_if.value  = oval_r;
  assign out_if.status = ostat_r;

  logic [COUNT_W-1:0] n_used;
  always_comb begin
    if (count_r < COUNT_W'(2)) n_used = COUNT_W'(2);
    else if (32'(count_r) > MAX_POINTS) n_used = COUNT_W'(MAX_POINTS);
    else n_used = count_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_if.kind == KIND_LOAD && 32'(in_if.point_index) < MAX_POINTS) begin
      x_mem[in_if.point_index[IW-1:0]] <= in_if.point_x;
      y_mem[in_if.point_index[IW-1:0]] <= in_if.point_y;
    end
    xr_d <= x_mem[xr_a];
    yr_d <= y_mem[rd_a];
    wr_d <= w_mem[wr_a];
    cr_d <= c_mem[rd_a];
  end

  // partial product
  logic [31:0] pa, pb;
  logic [63:0] pp;
  always_comb begin
    pa = mstep_r[0] ? ma_r[63:32] : ma_r[31:0];
    pb = mstep_r[1] ? mb_r[63:32] : mb_r[31:0];
    pp = 64'(pa) * 64'(pb);
  end
  logic [W2-1:0] mshift;
  logic [WORD_W:0] mres;
  assign mshift = mp_r >> FRAC_BITS;
  assign mres   = from_mag(mneg_r, mshift);

  logic [WORD_W:0] dres;
  assign dres = from_mag(dneg_r, dq_r);

  logic [WORD_W:0] sub_num, sub_den, sub_q, add_r;
  assign sub_num = sat_sub(a_r, b_r);
  assign sub_den = sat_sub(xa_r, xr_d);
  assign sub_q   = sat_sub(q_r, cf_r);
  assign add_r   = sat_add(acc_r, mres[WORD_W-1:0]);

  logic [WORD_W:0] rem_sh;
  assign rem_sh = {drem_r, dn_r[W2-1]};

  always_comb begin
    rd_a = i_r[IW-1:0];
    xr_a = i_r[IW-1:0];
    wr_a = i_r[IW-1:0];
    if (state_r == S_BRD) begin
      xr_a = i_r[IW-1:0];
      wr_a = i_r[IW-1:0];
    end else if (state_r == S_BRD2) begin
      xr_a = IW'(i_r + it_r);
      wr_a = IW'(i_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= COUNT_W'(2);
      stale_r  <= 1'b1;
      berr_r   <= ST_OK;
      ovalid_r <= 1'b0;
      mstep_r  <= '0;
      dcnt_r   <= '0;
    end else begin
      if (ovalid_r && out_if.ready) ovalid_r <= 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        count_r <= cfg_if.data;
        stale_r <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_if.kind == KIND_LOAD) begin
              if (32'(in_if.point_index) < MAX_POINTS) stale_r <= 1'b1;
            end else begin
              q_r  <= in_if.query_x;
              n_r  <= (IW+1)'(n_used);
              i_r  <= '0;
              it_r <= '0;
              if (stale_r) begin
                berr_r  <= ST_OK;
                sat_r   <= 1'b0;
                stale_r <= 1'b0;
                state_r <= S_CPY;
              end else begin
                state_r <= S_ERD;
              end
            end
          end
        end
        S_CPY: state_r <= S_CPY2;
        S_CPY2: begin
          w_mem[i_r[IW-1:0]] <= yr_d;
          if (i_r == '0) c_mem[0] <= yr_d;
          if (i_r + 1'b1 == n_r) begin
            i_r <= '0;
            it_r <= (IW+1)'(1);
            state_r <= S_BRD;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_CPY;
          end
        end
        S_BRD: state_r <= S_BRD2;
        S_BRD2: begin
          a_r  <= wr_d;
          xa_r <= xr_d;
          state_r <= S_DIV;
          dcnt_r <= '0;
        end
        S_DIV: begin
          if (dcnt_r == 8'd0) begin
            b_r <= wr_d;
            if (sub_den[WORD_W-1:0] == '0) begin
              berr_r <= ST_DUP;
              state_r <= S_ERD;
              i_r <= '0;
            end else begin
              if (sub_den[WORD_W]) sat_r <= 1'b1;
              dd_r <= mag_of(sub_den[WORD_W-1:0]);
              dneg_r <= sub_den[WORD_W-1];
              dcnt_r <= 8'd1;
            end
          end else if (dcnt_r == 8'd1) begin
            if (sub_num[WORD_W]) sat_r <= 1'b1;
            dneg_r <= dneg_r ^ sub_num[WORD_W-1];
            dn_r <= W2'(mag_of(sub_num[WORD_W-1:0])) << FRAC_BITS;
            drem_r <= '0;
            dq_r <= '0;
            dcnt_r <= 8'd2;
          end else if (dcnt_r < 8'(W2 + 2)) begin
            if (rem_sh[WORD_W] || rem_sh[WORD_W-1:0] >= dd_r) begin
              drem_r <= rem_sh[WORD_W-1:0] - dd_r;
              dq_r <= {dq_r[W2-2:0], 1'b1};
            end else begin
              drem_r <= rem_sh[WORD_W-1:0];
              dq_r <= {dq_r[W2-2:0], 1'b0};
            end
            dn_r <= {dn_r[W2-2:0], 1'b0};
            dcnt_r <= dcnt_r + 1'b1;
          end else begin
            state_r <= S_DWR;
          end
        end
        S_DWR: begin
          if (dres[WORD_W]) sat_r <= 1'b1;
          w_mem[i_r[IW-1:0]] <= dres[WORD_W-1:0];
          if (i_r == '0) c_mem[it_r[IW-1:0]] <= dres[WORD_W-1:0];
          if (i_r + it_r + 1'b1 == n_r) begin
            i_r <= '0;
            if (it_r + 1'b1 == n_r) begin
              state_r <= S_ERD;
              if (sat_r || dres[WORD_W]) berr_r <= ST_SAT;
            end else begin
              it_r <= it_r + 1'b1;
              state_r <= S_BRD;
            end
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_BRD;
          end
        end
        S_ERD: begin
          if (berr_r == ST_DUP) begin
            oval_r <= '0;
            ostat_r <= ST_DUP;
            ovalid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            if (i_r == '0) begin
              term_r <= WORD_W'(1) << FRAC_BITS;
              acc_r <= '0;
              sat_r <= 1'b0;
            end
            state_r <= S_ERD2;
          end
        end
        S_ERD2: begin
          ma_r <= mag_of(cr_d);
          mb_r <= mag_of(term_r);
          mneg_r <= cr_d[WORD_W-1] ^ term_r[WORD_W-1];
          mp_r <= '0;
          mstep_r <= '0;
          cf_r <= xr_d;
          state_r <= S_EMUL;
        end
        S_EMUL, S_EMUL2: begin
          mp_r <= mp_r + (W2'(pp) << (32 * (32'(mstep_r[0]) + 32'(mstep_r[1]))));
          if (mstep_r == 3'd3) begin
            mstep_r <= '0;
            state_r <= (state_r == S_EMUL) ? S_EACC : S_ETRM;
          end else begin
            mstep_r <= mstep_r + 1'b1;
          end
        end
        S_EACC: begin
          if (mres[WORD_W] || add_r[WORD_W]) sat_r <= 1'b1;
          acc_r <= add_r[WORD_W-1:0];
          if (i_r + 1'b1 == n_r) begin
            state_r <= S_OUT;
          end else begin
            ma_r <= mag_of(term_r);
            mb_r <= mag_of(sub_q[WORD_W-1:0]);
            mneg_r <= term_r[WORD_W-1] ^ sub_q[WORD_W-1];
            if (sub_q[WORD_W]) sat_r <= 1'b1;
            mp_r <= '0;
            state_r <= S_EMUL2;
          end
        end
        S_ETRM: begin
          if (mres[WORD_W]) sat_r <= 1'b1;
          term_r <= mres[WORD_W-1:0];
          i_r <= i_r + 1'b1;
          state_r <= S_ERD;
        end
        S_OUT: begin
          oval_r <= acc_r;
          ostat_r <= (sat_r || berr_r == ST_SAT) ? ST_SAT : ST_OK;
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/tb_newton_divided_difference_interp.sv
module tb_newton_divided_difference_interp
  import ndd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              kind;
    logic [3:0]        point_index;
    logic [WORD_W-1:0] point_x;
    logic [WORD_W-1:0] point_y;
    logic [WORD_W-1:0] query_x;
  } interp_req_t;

  typedef struct {
    logic [WORD_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } interp_res_t;

  logic clk;
  logic rst_n;

  ndd_in_if  in_if ();
  ndd_out_if out_if ();
  ndd_cfg_if cfg_if ();

  newton_divided_difference_interp dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  interp_req_t req_q[$];
  interp_res_t expected_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned err_cnt;
  int unsigned eval_cnt;
  int unsigned load_cnt;
  int unsigned dup_cnt;
  int unsigned sat_cnt;

  logic [WORD_W-1:0] px[16];
  logic [WORD_W-1:0] py[16];
  logic [WORD_W-1:0] cf[16];
  logic [WORD_W-1:0] col[16];
  logic              stale;
  logic [1:0]        bld_err;
  logic [COUNT_W-1:0] npts_reg;
  logic              loaded[16];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? -v : v;
  endfunction

  function automatic logic [WORD_W-1:0] clamp_mag(input logic neg, input logic [127:0] m,
                                                  inout logic sat);
    logic [WORD_W-1:0] lim;
    lim = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    if (m[127:64] != 0 || m[63:0] > lim) begin
      sat = 1'b1;
      return lim;
    end
    return neg ? -m[63:0] : m[63:0];
  endfunction

  function automatic logic [WORD_W-1:0] q_add(input logic [WORD_W-1:0] a,
                                              input logic [WORD_W-1:0] b, inout logic sat);
    logic [WORD_W-1:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      sat = 1'b1;
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] q_sub(input logic [WORD_W-1:0] a,
                                              input logic [WORD_W-1:0] b, inout logic sat);
    logic [WORD_W-1:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      sat = 1'b1;
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] q_mul(input logic [WORD_W-1:0] a,
                                              input logic [WORD_W-1:0] b, inout logic sat);
    logic [127:0] p;
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    return clamp_mag(a[63] ^ b[63], p >> 32, sat);
  endfunction

  function automatic logic [WORD_W-1:0] q_div(input logic [WORD_W-1:0] n,
                                              input logic [WORD_W-1:0] d, inout logic sat);
    logic [127:0] q;
    q = ({64'd0, mag(n)} << 32) / {64'd0, mag(d)};
    return clamp_mag(n[63] ^ d[63], q, sat);
  endfunction

  task automatic rebuild_coefs(input int n);
    logic sat;
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] den;
    sat = 1'b0;
    bld_err = 2'd0;
    for (int i = 0; i < n; i++) col[i] = py[i];
    cf[0] = col[0];
    for (int it = 1; it < n; it++) begin
      for (int i = 0; i + it < n; i++) begin
        num = q_sub(col[i], col[i+1], sat);
        den = q_sub(px[i], px[i+it], sat);
        if (den == 0) begin
          bld_err = 2'd1;
          return;
        end
        col[i] = q_div(num, den, sat);
      end
      cf[it] = col[0];
    end
    if (sat) bld_err = 2'd2;
  endtask

  task automatic predict_interp(input interp_req_t r);
    int n;
    logic sat;
    logic [WORD_W-1:0] term;
    logic [WORD_W-1:0] acc;
    interp_res_t res;
    if (r.kind == KIND_LOAD) begin
      px[r.point_index] = r.point_x;
      py[r.point_index] = r.point_y;
      stale = 1'b1;
      return;
    end
    n = (npts_reg < 2) ? 2 : (npts_reg > 16) ? 16 : npts_reg;
    if (stale) begin
      rebuild_coefs(n);
      stale = 1'b0;
    end
    if (bld_err == 2'd1) begin
      res.value = '0;
      res.status = ST_DUP;
    end else begin
      sat = 1'b0;
      term = 64'h1_0000_0000;
      acc = '0;
      for (int i = 0; i < n; i++) begin
        acc = q_add(acc, q_mul(cf[i], term, sat), sat);
        if (i + 1 < n) term = q_mul(term, q_sub(r.query_x, px[i], sat), sat);
      end
      res.value = acc;
      res.status = (sat || bld_err == 2'd2) ? ST_SAT : ST_OK;
    end
    expected_q = {expected_q, res};
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        interp_req_t r;
        r = req_q.pop_front();
        predict_interp(r);
        if (r.kind == KIND_LOAD) load_cnt++;
        else eval_cnt++;
        in_if.valid <= 1'b1;
        in_if.kind <= r.kind;
        in_if.point_index <= r.point_index;
        in_if.point_x <= r.point_x;
        in_if.point_y <= r.point_y;
        in_if.query_x <= r.query_x;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result value=%h status=%0d", out_if.value, out_if.status);
          err_cnt++;
        end else begin
          interp_res_t e;
          e = expected_q.pop_front();
          if (out_if.value !== e.value) begin
            $error("value expected %h actual %h", e.value, out_if.value);
            err_cnt++;
          end
          if (out_if.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_if.status);
            err_cnt++;
          end
          if (e.status == ST_DUP) dup_cnt++;
          if (e.status == ST_SAT) sat_cnt++;
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word(input int mode);
    logic [WORD_W-1:0] w;
    w = {$urandom, $urandom};
    case (mode)
      0: return w;
      1: return {{24{w[39]}}, w[39:0]};
      default: return {{30{w[33]}}, w[33:0]};
    endcase
  endfunction

  task automatic push_load(input int idx, input logic [WORD_W-1:0] x,
                           input logic [WORD_W-1:0] y);
    interp_req_t r;
    r.kind = KIND_LOAD;
    r.point_index = 4'(idx);
    r.point_x = x;
    r.point_y = y;
    r.query_x = {$urandom, $urandom};
    req_q = {req_q, r};
    loaded[idx] = 1'b1;
  endtask

  task automatic push_eval(input logic [WORD_W-1:0] q);
    interp_req_t r;
    r.kind = KIND_EVAL;
    r.point_index = 4'($urandom);
    r.point_x = {$urandom, $urandom};
    r.point_y = {$urandom, $urandom};
    r.query_x = q;
    req_q = {req_q, r};
  endtask

  task automatic drain_and_idle();
    while (req_q.size() > 0 || in_if.valid || expected_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] v);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    npts_reg = v;
    stale = 1'b1;
  endtask

  task automatic random_phase(input int items);
    int mode;
    int used;
    for (int k = 0; k < items; k++) begin
      mode = $urandom_range(2);
      used = (npts_reg < 2) ? 2 : (npts_reg > 16) ? 16 : npts_reg;
      if ($urandom_range(99) < 45) begin
        int idx;
        idx = $urandom_range(15);
        // distinct x spacing keeps most rebuilds well formed
        if ($urandom_range(9) == 0) push_load(idx, rand_word(mode), rand_word(mode));
        else push_load(idx, {32'(idx * 3 + $urandom_range(2)) - 32'd20, $urandom},
                       rand_word(mode));
      end else begin
        for (int i = 0; i < used; i++)
          if (!loaded[i]) push_load(i, {32'(i * 3) - 32'd20, $urandom}, rand_word(2));
        push_eval(($urandom_range(3) == 0) ? rand_word(0) :
                  {32'($urandom_range(60)) - 32'd30, $urandom});
      end
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] counts[6];
    counts = '{5'd0, 5'd31, 5'd16, 5'd3, 5'd5, 5'd2};
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_LOAD;
    in_if.point_index = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.query_x = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    err_cnt = 0; eval_cnt = 0; load_cnt = 0; dup_cnt = 0; sat_cnt = 0;
    for (int i = 0; i < 16; i++) begin
      px[i] = '0; py[i] = '0; cf[i] = '0; col[i] = '0; loaded[i] = 1'b0;
    end
    stale = 1'b1;
    bld_err = 2'd0;
    npts_reg = 5'd2;
    send_idle_pct = 14;
    recv_idle_pct = 76;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, duplicate x, saturation
    push_load(0, 64'h0000_0001_0000_0000, 64'h0000_0002_0000_0000);
    push_load(1, 64'h0000_0003_0000_0000, 64'h0000_0008_0000_0000);
    push_eval(64'h0000_0002_0000_0000);
    push_eval(64'h8000_0000_0000_0000);
    push_eval(64'h7FFF_FFFF_FFFF_FFFF);
    push_load(1, 64'h0000_0001_0000_0000, 64'h0000_0005_0000_0000);
    push_eval(64'h0);
    push_eval(64'hFFFF_FFFF_FFFF_FFFF);
    push_load(0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    push_load(1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    push_eval(64'h0);
    push_load(0, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF);
    push_load(1, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
    push_eval(64'h0000_0000_0000_0002);
    push_load(15, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_load(0, 64'h0000_0001_0000_0000, 64'h0000_0002_0000_0000);
    push_load(1, 64'hFFFF_FFFF_0000_0000, 64'h0);
    push_eval(64'h0000_0000_8000_0000);
    drain_and_idle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 76; recv_idle_pct = 14; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_count(counts[ph]);
      random_phase((counts[ph] == 5'd16 || counts[ph] == 5'd31) ? 60 : 160);
      drain_and_idle();
    end

    $display("loads %0d, evaluations %0d (duplicate x %0d, saturated %0d)",
             load_cnt, eval_cnt, dup_cnt, sat_cnt);
    $display("point counts swept over 0, 31, 16, 3, 5 and 2 under three idle profiles");
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

endmodule
